/* rtl/trd_pkg.sv */
// Shared types and constants of the tandem repeat detector.
package trd_pkg;

   // Fixed widths of the configuration and result fields.
   localparam int unsigned PERIOD_W       = 3;
   localparam int unsigned MIN_REPEATS_W  = 4;
   localparam int unsigned SEG_START_W    = 32;
   localparam int unsigned CSR_INDEX_W    = 2;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned RUN_START_W    = 32;
   localparam int unsigned COPIES_W       = 16;
   localparam int unsigned UNIT_PATTERN_W = 10;
   localparam int unsigned UNIT_LENGTH_W  = 3;

   // Reset values of the configuration registers.
   localparam logic [PERIOD_W-1:0]      PERIOD_RESET      = 3'd2;
   localparam logic [MIN_REPEATS_W-1:0] MIN_REPEATS_RESET = 4'd4;
   localparam logic [SEG_START_W-1:0]   SEG_START_RESET   = 32'd0;

   // Shortest repeat unit and smallest copy count that are honoured.
   localparam logic [PERIOD_W-1:0]      PERIOD_FLOOR      = 3'd2;
   localparam logic [MIN_REPEATS_W-1:0] MIN_REPEATS_FLOOR = 4'd2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PERIOD        = 2'd0,
      CSR_MIN_REPEATS   = 2'd1,
      CSR_SEGMENT_START = 2'd2
   } csr_index_type;

   // One reported repeat run.
   typedef struct packed {
      logic [RUN_START_W-1:0]    run_start;
      logic [COPIES_W-1:0]       copies;
      logic [UNIT_PATTERN_W-1:0] unit_pattern;
      logic [UNIT_LENGTH_W-1:0]  unit_length;
   } result_type;

   // Control that every history cell receives.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

/* rtl/trd_cell.sv */
// One history cell: holds a base, passes it on and compares its incoming base with a partner.
module trd_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  trd_pkg::cell_ctl_type ctl,
   input  logic [1:0]            base_prev,
   input  logic [1:0]            partner,
   output logic [1:0]            base_next,
   output logic [1:0]            base_q,
   output logic                  same
);

   logic [1:0] base_ff;
   logic [1:0] base_in;

   // The value this cell takes if the current item is accepted.
   assign base_next = ctl.clear ? 2'd0 : base_prev;
   assign base_in   = ctl.shift ? base_next : base_ff;
   assign base_q    = base_ff;
   assign same      = (base_next == partner);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 2'd0;
      end else begin
         base_ff <= base_in;
      end
   end

endmodule

/* rtl/trd_out_buf.sv */
// Output register with a skid stage for the result channel.
module trd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  trd_pkg::result_type  push_data,
   input  logic                 out_stall,
   output logic                 out_valid,
   output trd_pkg::result_type  out_data,
   output logic                 full
);

   logic                out_valid_ff;
   logic                out_valid_in;
   trd_pkg::result_type out_data_ff;
   trd_pkg::result_type out_data_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   trd_pkg::result_type skid_data_ff;
   trd_pkg::result_type skid_data_in;
   logic                pop;

   assign pop = out_valid_ff & ~out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

/* rtl/tandem_repeat_detector.sv */
// Top level of the tandem repeat detector: history cell chain, run tracking and result port.
//
// Usage. Bases arrive on the req_ channel, one item per accepted edge (req_valid high and
// req_stall low). req_restart opens a new segment: the history and the open run are
// dropped, and this base takes the position held in the segment start register.
// Reports leave on the rsp_ channel, one item per accepted edge (rsp_valid high and
// rsp_stall low). The csr_ channel writes period, min_repeats and segment start; it is
// always ready and should only be used while the block is idle.
// A report enters the output register, or the skid stage while that register holds one, when
// the base that closes the run is accepted. Throughput: one base every cycle while req_stall
// is low. The whole step of one base, a compare of at most MAX_PERIOD cells and one small
// multiply for the run start, is combinational, as the next base needs the state it leaves.
// Stalling: the output register and a skid stage lie between the detector and rsp_, so
// bases keep being taken while one report waits. req_stall rises once both hold a
// report and falls as soon as the receiver takes one.
// Reset clears the history, counters, position and output stages, and loads period 2,
// min_repeats 4 and segment start 0.
module tandem_repeat_detector #(
   parameter int unsigned MAX_PERIOD    = 5,
   parameter int unsigned POSITION_BITS = 32,
   parameter int unsigned COUNT_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Base input channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_base,
   input  logic                                 req_restart,
   // Report channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [trd_pkg::RUN_START_W-1:0]      rsp_run_start,
   output logic [trd_pkg::COPIES_W-1:0]         rsp_copies,
   output logic [trd_pkg::UNIT_PATTERN_W-1:0]   rsp_unit_pattern,
   output logic [trd_pkg::UNIT_LENGTH_W-1:0]    rsp_unit_length,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [trd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0]       csr_data
);

   // The history holds two whole units of the longest period.
   localparam int unsigned HIST_DEPTH = 2 * MAX_PERIOD;
   localparam int unsigned NW         = $clog2(MAX_PERIOD + 1);
   localparam int unsigned WAIT_W     = (MAX_PERIOD > 2) ? $clog2(MAX_PERIOD) : 1;
   localparam int unsigned SEEN_W     = $clog2(HIST_DEPTH + 1);
   localparam int unsigned UNIT_W     = 2 * MAX_PERIOD;
   localparam int unsigned PROD_W     = NW + COUNT_BITS;
   localparam int unsigned SUM_W      = (POSITION_BITS > PROD_W) ? POSITION_BITS : PROD_W;
   localparam int unsigned CW         = (COUNT_BITS > trd_pkg::COPIES_W) ?
                                        COUNT_BITS : trd_pkg::COPIES_W;

   // Configuration registers.
   logic [trd_pkg::PERIOD_W-1:0]      period_ff;
   logic [trd_pkg::MIN_REPEATS_W-1:0] min_repeats_ff;
   logic [trd_pkg::SEG_START_W-1:0]   seg_start_ff;

   // Run tracking state.
   logic [SEEN_W-1:0]        bases_seen_ff;
   logic [SEEN_W-1:0]        bases_seen_in;
   logic [WAIT_W-1:0]        wait_count_ff;
   logic [WAIT_W-1:0]        wait_count_in;
   logic [COUNT_BITS-1:0]    run_count_ff;
   logic [COUNT_BITS-1:0]    run_count_in;
   logic [UNIT_W-1:0]        last_unit_ff;
   logic [UNIT_W-1:0]        last_unit_in;
   logic [POSITION_BITS-1:0] position_ff;
   logic [POSITION_BITS-1:0] position_in;

   // Cell chain.
   trd_pkg::cell_ctl_type cell_ctl;
   logic [1:0]            cell_prev   [HIST_DEPTH];
   logic [1:0]            cell_next   [HIST_DEPTH];
   logic [1:0]            cell_q      [HIST_DEPTH];
   logic [1:0]            cell_partner[HIST_DEPTH];
   logic                  cell_same   [HIST_DEPTH];

   // Step logic.
   logic                     take;
   logic [NW-1:0]            n;
   logic [POSITION_BITS-1:0] cur;
   logic [SEEN_W-1:0]        seen_now;
   logic [WAIT_W-1:0]        wait_now;
   logic [COUNT_BITS-1:0]    run_now;
   logic [UNIT_W-1:0]        unit_now;
   logic                     judge;
   logic                     match;
   logic [UNIT_W-1:0]        unit;
   logic [COUNT_BITS-1:0]    copies;
   logic [trd_pkg::MIN_REPEATS_W-1:0] need;
   logic [trd_pkg::UNIT_PATTERN_W-1:0] lu;
   logic                     degenerate;
   logic                     emit;
   logic [PROD_W-1:0]        span;
   logic [SUM_W-1:0]         start_wide;
   logic [CW-1:0]            copies_wide;
   trd_pkg::result_type      result;
   trd_pkg::result_type      out_data;
   logic                     buf_full;

   // ------------------------------------------------------------------
   // Configuration port: always ready, writes land at once.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= trd_pkg::PERIOD_RESET;
         min_repeats_ff <= trd_pkg::MIN_REPEATS_RESET;
         seg_start_ff   <= trd_pkg::SEG_START_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            trd_pkg::CSR_PERIOD:
               period_ff <= csr_data[trd_pkg::PERIOD_W-1:0];
            trd_pkg::CSR_MIN_REPEATS:
               min_repeats_ff <= csr_data[trd_pkg::MIN_REPEATS_W-1:0];
            trd_pkg::CSR_SEGMENT_START:
               seg_start_ff <= csr_data[trd_pkg::SEG_START_W-1:0];
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   // A base is taken whenever the skid stage still has room.
   assign req_stall = buf_full;
   assign take      = req_valid & ~req_stall;

   // The period in force, clamped into the supported range.
   always_comb begin
      if (int'(period_ff) > MAX_PERIOD) begin
         n = NW'(MAX_PERIOD);
      end else if (period_ff < trd_pkg::PERIOD_FLOOR) begin
         n = NW'(trd_pkg::PERIOD_FLOOR);
      end else begin
         n = NW'(period_ff);
      end
   end

   // ------------------------------------------------------------------
   // History chain. Cell k holds the base k items ago; on a restart every
   // cell but the first is cleared as the new base enters.
   // ------------------------------------------------------------------
   assign cell_ctl.shift = take;
   assign cell_ctl.clear = req_restart;

   for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
      trd_pkg::cell_ctl_type ctl_i;

      if (i == 0) begin : g_head
         assign cell_prev[i] = req_base;
         assign ctl_i.shift  = cell_ctl.shift;
         assign ctl_i.clear  = 1'b0;
      end else begin : g_body
         assign cell_prev[i] = cell_q[i-1];
         assign ctl_i        = cell_ctl;
      end

      // Each cell is compared with the cell one period further back.
      always_comb begin
         cell_partner[i] = cell_next[i];
         for (int p = 2; p <= MAX_PERIOD; p++) begin
            if (n == NW'(p) && (i + p) < HIST_DEPTH) begin
               cell_partner[i] = cell_next[(i + p) % HIST_DEPTH];
            end
         end
      end

      trd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl_i),
         .base_prev (cell_prev[i]),
         .partner   (cell_partner[i]),
         .base_next (cell_next[i]),
         .base_q    (cell_q[i]),
         .same      (cell_same[i])
      );
   end

   // ------------------------------------------------------------------
   // Window judgement and run tracking for the base being offered.
   // ------------------------------------------------------------------
   always_comb begin
      // A restart wipes the segment state before this base is counted.
      cur      = req_restart ? POSITION_BITS'(seg_start_ff) : position_ff;
      seen_now = req_restart ? '0 : bases_seen_ff;
      wait_now = req_restart ? '0 : wait_count_ff;
      run_now  = req_restart ? '0 : run_count_ff;
      unit_now = req_restart ? '0 : last_unit_ff;

      position_in   = cur + POSITION_BITS'(1);
      bases_seen_in = (seen_now < SEEN_W'(HIST_DEPTH)) ? seen_now + SEEN_W'(1) : seen_now;

      judge = (wait_now == '0) && (bases_seen_in >= SEEN_W'({n, 1'b0}));

      // The newest window matches when every cell of it equals its partner.
      match = 1'b1;
      for (int i = 0; i < MAX_PERIOD; i++) begin
         if (NW'(i) < n && !cell_same[i]) begin
            match = 1'b0;
         end
      end

      // Unit of the newest window, oldest base in the lowest bits.
      unit = '0;
      for (int p = 2; p <= MAX_PERIOD; p++) begin
         if (n == NW'(p)) begin
            for (int j = 0; j < p; j++) begin
               unit[2*j +: 2] = cell_next[p - 1 - j];
            end
         end
      end

      copies = (run_now == '1) ? run_now : run_now + COUNT_BITS'(1);
      need   = (min_repeats_ff < trd_pkg::MIN_REPEATS_FLOOR) ?
               trd_pkg::MIN_REPEATS_FLOOR : min_repeats_ff;

      // Units of one base at period three or five, or abab at period four, are not reported.
      lu = trd_pkg::UNIT_PATTERN_W'(unit_now);
      degenerate = 1'b0;
      if (n == NW'(3)) begin
         degenerate = (lu[1:0] == lu[3:2]) && (lu[1:0] == lu[5:4]);
      end else if (n == NW'(4)) begin
         degenerate = (lu[1:0] == lu[5:4]) && (lu[3:2] == lu[7:6]);
      end else if (n == NW'(5)) begin
         degenerate = (lu[1:0] == lu[3:2]) && (lu[1:0] == lu[5:4]) &&
                      (lu[1:0] == lu[7:6]) && (lu[1:0] == lu[9:8]);
      end

      wait_count_in = wait_now;
      run_count_in  = run_now;
      last_unit_in  = unit_now;
      emit          = 1'b0;
      if (wait_now != '0) begin
         wait_count_in = wait_now - WAIT_W'(1);
      end else if (judge) begin
         if (match) begin
            run_count_in  = (run_now == '1) ? run_now : run_now + COUNT_BITS'(1);
            last_unit_in  = unit;
            wait_count_in = WAIT_W'(n - NW'(1));
         end else if (run_now != '0) begin
            emit         = (copies >= COUNT_BITS'(need)) && !degenerate;
            run_count_in = '0;
         end
      end
   end

   // Run start: window start minus one whole period per copy, wrapping.
   assign span       = PROD_W'(n) * PROD_W'(copies);
   assign start_wide = SUM_W'(cur) - SUM_W'(n - NW'(1)) - SUM_W'(span);
   assign copies_wide = CW'(copies);

   always_comb begin
      result.run_start    = trd_pkg::RUN_START_W'(start_wide[POSITION_BITS-1:0]);
      result.copies       = (copies_wide > CW'({trd_pkg::COPIES_W{1'b1}})) ?
                            {trd_pkg::COPIES_W{1'b1}} : trd_pkg::COPIES_W'(copies_wide);
      result.unit_pattern = lu;
      result.unit_length  = trd_pkg::UNIT_LENGTH_W'(n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bases_seen_ff <= '0;
         wait_count_ff <= '0;
         run_count_ff  <= '0;
         last_unit_ff  <= '0;
         position_ff   <= '0;
      end else if (take) begin
         bases_seen_ff <= bases_seen_in;
         wait_count_ff <= wait_count_in;
         run_count_ff  <= run_count_in;
         last_unit_ff  <= last_unit_in;
         position_ff   <= position_in;
      end
   end

   // ------------------------------------------------------------------
   // Result port.
   // ------------------------------------------------------------------
   trd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take & emit),
      .push_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (buf_full)
   );

   assign rsp_run_start    = out_data.run_start;
   assign rsp_copies       = out_data.copies;
   assign rsp_unit_pattern = out_data.unit_pattern;
   assign rsp_unit_length  = out_data.unit_length;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The skid stage only fills behind a waiting report.
   a_stall_has_report: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no report waiting");

   // Bases skipped after a matching window never close a run.
   a_skip_no_report: assert property (@(posedge clock) disable iff (reset)
      (take && !req_restart && wait_count_ff != '0) |-> !emit)
      else $error("report raised while skipping bases");

   // A report always clears the run count.
   a_report_clears_run: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> (run_count_ff == '0))
      else $error("run count not cleared after report");

   // The skip counter never exceeds the longest period less one.
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      int'(wait_count_ff) < MAX_PERIOD)
      else $error("skip counter out of range");

endmodule
